### rtl/link_delay_loss_queue_macros.svh
// Assertion macros for the link delay loss queue.
// Used by the controller and datapath modules; no other dependencies.
`ifndef LINK_DELAY_LOSS_QUEUE_MACROS_SVH
`define LINK_DELAY_LOSS_QUEUE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define LDLQ_ASSERT_IMPLIES(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("assertion failed");
`define LDLQ_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("assertion failed");
`else
`define LDLQ_ASSERT_IMPLIES(label, clk, rst, cond, prop)
`define LDLQ_ASSERT_NEXT(label, clk, rst, cond, prop)
`endif
`endif

### rtl/ldlq_pkg.sv
// Shared types and constants for the link delay loss queue.
// No dependencies.
`timescale 1ns / 1ps
package ldlq_pkg;
   localparam logic [1:0] REQ_SUBMIT  = 2'd0;
   localparam logic [1:0] REQ_POP     = 2'd1;
   localparam logic [1:0] REQ_FLUSH   = 2'd2;
   localparam logic [1:0] REQ_RESTART = 2'd3;

   localparam logic [1:0] CSR_LATENCY = 2'd0;
   localparam logic [1:0] CSR_JITTER  = 2'd1;
   localparam logic [1:0] CSR_LOSS    = 2'd2;
   localparam logic [1:0] CSR_SEED    = 2'd3;

   localparam logic [31:0] SEED_DEFAULT = 32'h9E3779B9;
   localparam logic [6:0]  LOSS_MODULUS = 7'd100;
   // ceil(2^37 / 100): bits 63:37 of x * LOSS_RECIP give x / 100 for any 32-bit x
   localparam logic [31:0] LOSS_RECIP   = 32'h51EB851F;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DRAW_LOSS,
      ST_DIV_LOSS,
      ST_DRAW_JIT,
      ST_DIV_JIT,
      ST_CLAMP,
      ST_READ,
      ST_EVICT,
      ST_WRITE,
      ST_POP,
      ST_DONE
   } state_type;

   // Commands from controller to datapath.
   typedef struct packed {
      logic capture;     // latch request fields
      logic draw;        // advance generator
      logic div_loss;    // start modulo by 100
      logic div_jit;     // start modulo by jitter+1
      logic add_jit;     // add remainder to delay
      logic clamp;       // form release time
      logic read_head;   // read head entry
      logic evict;       // drop head as forced output
      logic write;       // store new entry
      logic drop;        // count random drop
      logic pop;         // release head
      logic flush;
      logic restart;
      logic finish;      // load response register
   } cmd_type;

   typedef struct packed {
      logic [1:0] req_type;
      logic       size_ok;
      logic       loss_en;
      logic       jit_en;
      logic       div_busy;
      logic       lost;
      logic       full;
   } status_type;
endpackage

### rtl/ldlq_if.sv
// Valid/ready channel interfaces for requests and responses.
// Depends on nothing.
`timescale 1ns / 1ps
interface ldlq_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  req_type;
   logic [63:0] payload;
   logic [11:0] pkt_size;
   logic        reliable;
   logic [31:0] now_ms;
   modport source (output valid, req_type, payload, pkt_size, reliable, now_ms,
                   input ready);
   modport sink (input valid, req_type, payload, pkt_size, reliable, now_ms,
                 output ready);
endinterface

interface ldlq_rsp_if;
   logic        valid;
   logic        ready;
   logic        accepted;
   logic        out_valid;
   logic [63:0] out_payload;
   logic [11:0] out_size;
   logic        forced_out;
   logic [8:0]  queued_now;
   logic [31:0] dropped_total;
   logic [31:0] overflow_total;
   logic [31:0] delayed_total;
   logic [31:0] released_total;
   logic [8:0]  peak_occupancy;
   modport source (output valid, accepted, out_valid, out_payload, out_size, forced_out,
                   queued_now, dropped_total, overflow_total, delayed_total,
                   released_total, peak_occupancy, input ready);
   modport sink (input valid, accepted, out_valid, out_payload, out_size, forced_out,
                 queued_now, dropped_total, overflow_total, delayed_total,
                 released_total, peak_occupancy, output ready);
endinterface

### rtl/ldlq_ctrl.sv
// Sequencer for the link delay loss queue: one request at a time.
// Depends on ldlq_pkg and the assertion macros header.
`timescale 1ns / 1ps
`include "link_delay_loss_queue_macros.svh"
module ldlq_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_fire,
   input  logic                  rsp_slot_free,
   input  ldlq_pkg::status_type  status,
   output logic                  busy,
   output ldlq_pkg::cmd_type     cmd
);
   ldlq_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ldlq_pkg::ST_IDLE;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ldlq_pkg::ST_IDLE: begin
            if (req_fire) begin
               case (status.req_type)
                  ldlq_pkg::REQ_SUBMIT: state_in = ldlq_pkg::ST_DRAW_LOSS;
                  ldlq_pkg::REQ_POP:    state_in = ldlq_pkg::ST_READ;
                  default:              state_in = ldlq_pkg::ST_DONE;
               endcase
            end
         end
         ldlq_pkg::ST_DRAW_LOSS: begin
            if (!status.size_ok)     state_in = ldlq_pkg::ST_DONE;
            else if (status.loss_en) state_in = ldlq_pkg::ST_DIV_LOSS;
            else if (status.jit_en)  state_in = ldlq_pkg::ST_DRAW_JIT;
            else                     state_in = ldlq_pkg::ST_CLAMP;
         end
         ldlq_pkg::ST_DIV_LOSS: begin
            if (!status.div_busy) begin
               if (status.lost)        state_in = ldlq_pkg::ST_DONE;
               else if (status.jit_en) state_in = ldlq_pkg::ST_DRAW_JIT;
               else                    state_in = ldlq_pkg::ST_CLAMP;
            end
         end
         ldlq_pkg::ST_DRAW_JIT: state_in = ldlq_pkg::ST_DIV_JIT;
         ldlq_pkg::ST_DIV_JIT: begin
            if (!status.div_busy) state_in = ldlq_pkg::ST_CLAMP;
         end
         ldlq_pkg::ST_CLAMP: state_in = status.full ? ldlq_pkg::ST_READ : ldlq_pkg::ST_WRITE;
         ldlq_pkg::ST_READ: begin
            state_in = (status.req_type == ldlq_pkg::REQ_POP) ? ldlq_pkg::ST_POP
                                                              : ldlq_pkg::ST_EVICT;
         end
         ldlq_pkg::ST_EVICT: state_in = ldlq_pkg::ST_WRITE;
         ldlq_pkg::ST_WRITE: state_in = ldlq_pkg::ST_DONE;
         ldlq_pkg::ST_POP:   state_in = ldlq_pkg::ST_DONE;
         ldlq_pkg::ST_DONE: begin
            if (rsp_slot_free) state_in = ldlq_pkg::ST_IDLE;
         end
         default: state_in = ldlq_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      busy = (state_ff != ldlq_pkg::ST_IDLE);
      case (state_ff)
         ldlq_pkg::ST_IDLE: begin
            cmd.capture = req_fire;
            cmd.flush   = req_fire && (status.req_type == ldlq_pkg::REQ_FLUSH);
            cmd.restart = req_fire && (status.req_type == ldlq_pkg::REQ_RESTART);
         end
         ldlq_pkg::ST_DRAW_LOSS: begin
            cmd.draw     = status.size_ok && status.loss_en;
            cmd.div_loss = status.size_ok && status.loss_en;
         end
         ldlq_pkg::ST_DIV_LOSS: cmd.drop = !status.div_busy && status.lost;
         ldlq_pkg::ST_DRAW_JIT: begin
            cmd.draw    = 1'b1;
            cmd.div_jit = 1'b1;
         end
         ldlq_pkg::ST_DIV_JIT: cmd.add_jit = !status.div_busy;
         ldlq_pkg::ST_CLAMP:   cmd.clamp = 1'b1;
         ldlq_pkg::ST_READ:    cmd.read_head = 1'b1;
         ldlq_pkg::ST_EVICT:   cmd.evict = 1'b1;
         ldlq_pkg::ST_WRITE:   cmd.write = 1'b1;
         ldlq_pkg::ST_POP:     cmd.pop = 1'b1;
         ldlq_pkg::ST_DONE:    cmd.finish = rsp_slot_free;
         default: ;
      endcase
   end

   `LDLQ_ASSERT_IMPLIES(a_capture_idle, clock, reset, cmd.capture, state_ff == ldlq_pkg::ST_IDLE)
   `LDLQ_ASSERT_NEXT(a_finish_idle, clock, reset, cmd.finish, state_ff == ldlq_pkg::ST_IDLE)
   `LDLQ_ASSERT_IMPLIES(a_onehot_cmd, clock, reset, 1'b1, $onehot0({cmd.write, cmd.pop, cmd.evict}))
endmodule

### rtl/ldlq_dp.sv
// Datapath: generator, loss and jitter remainders, queue memories, counters, response.
// Depends on ldlq_pkg and the assertion macros header.
`timescale 1ns / 1ps
`include "link_delay_loss_queue_macros.svh"
module ldlq_dp #(
   parameter int QUEUE_DEPTH      = 256,
   parameter int MAX_PACKET_BYTES = 2048
) (
   input  logic                 clock,
   input  logic                 reset,
   input  ldlq_pkg::cmd_type    cmd,
   output ldlq_pkg::status_type status,
   input  logic                 csr_write_enable,
   input  logic [1:0]           csr_index,
   input  logic [31:0]          csr_write_data,
   input  logic [1:0]           req_type,
   input  logic [63:0]          req_payload,
   input  logic [11:0]          req_pkt_size,
   input  logic                 req_reliable,
   input  logic [31:0]          req_now_ms,
   output logic                 rsp_accepted,
   output logic                 rsp_out_valid,
   output logic [63:0]          rsp_out_payload,
   output logic [11:0]          rsp_out_size,
   output logic                 rsp_forced_out,
   output logic [8:0]           rsp_queued_now,
   output logic [31:0]          rsp_dropped_total,
   output logic [31:0]          rsp_overflow_total,
   output logic [31:0]          rsp_delayed_total,
   output logic [31:0]          rsp_released_total,
   output logic [8:0]           rsp_peak_occupancy
);
   localparam int AW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

   logic [12:0] latency_ff;
   logic [9:0]  jitter_ff;
   logic [6:0]  loss_ff;
   logic [31:0] seed_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         latency_ff <= '0; jitter_ff <= '0; loss_ff <= '0; seed_ff <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            ldlq_pkg::CSR_LATENCY: latency_ff <= csr_write_data[12:0];
            ldlq_pkg::CSR_JITTER:  jitter_ff  <= csr_write_data[9:0];
            ldlq_pkg::CSR_LOSS:    loss_ff    <= csr_write_data[6:0];
            ldlq_pkg::CSR_SEED:    seed_ff    <= csr_write_data;
            default: ;
         endcase
      end
   end

   // Captured request
   logic [1:0]  type_ff;
   logic [63:0] pay_ff;
   logic [11:0] size_ff;
   logic        rel_ff;
   logic [31:0] now_ff;
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         type_ff <= req_type; pay_ff <= req_payload; size_ff <= req_pkt_size;
         rel_ff <= req_reliable; now_ff <= req_now_ms;
      end
   end

   // xorshift32
   logic [31:0] rng_ff, x1, x2, x3;
   always_comb begin
      x1 = rng_ff ^ (rng_ff << 13);
      x2 = x1 ^ (x1 >> 17);
      x3 = x2 ^ (x2 << 5);
   end
   always_ff @(posedge clock) begin
      if (reset)            rng_ff <= ldlq_pkg::SEED_DEFAULT;
      else if (cmd.restart) rng_ff <= (seed_ff != '0) ? seed_ff : ldlq_pkg::SEED_DEFAULT;
      else if (cmd.draw)    rng_ff <= (x3 != '0) ? x3 : ldlq_pkg::SEED_DEFAULT;
   end
   logic [31:0] draw_val;
   assign draw_val = (x3 != '0) ? x3 : ldlq_pkg::SEED_DEFAULT;

   // Loss draw: remainder by 100 from a reciprocal multiply, then a
   // multiply-back and subtract on the next cycle.
   // Jitter draw: restoring divider, one quotient bit per cycle; keeps remainder only.
   logic [31:0] dividend_ff;
   logic [10:0] rem_ff, divisor_ff;
   logic [5:0]  cnt_ff;
   logic        recip_ff;
   logic [26:0] quot_ff;
   logic [63:0] recip_prod;
   logic [31:0] quot_x100, loss_diff;
   logic [11:0] trial;
   assign trial      = {rem_ff, dividend_ff[31]} - {1'b0, divisor_ff};
   assign recip_prod = 64'(dividend_ff) * 64'(ldlq_pkg::LOSS_RECIP);
   assign quot_x100  = 32'(quot_ff) * 32'(ldlq_pkg::LOSS_MODULUS);
   assign loss_diff  = dividend_ff - quot_x100;
   always_ff @(posedge clock) begin
      if (reset) cnt_ff <= '0;
      else if (cmd.div_loss || cmd.div_jit) begin
         dividend_ff <= draw_val;
         rem_ff      <= '0;
         divisor_ff  <= 11'(jitter_ff) + 11'd1;
         recip_ff    <= cmd.div_loss;
         cnt_ff      <= cmd.div_loss ? 6'd2 : 6'd32;
      end else if (cnt_ff != '0) begin
         cnt_ff <= cnt_ff - 6'd1;
         if (recip_ff) begin
            if (cnt_ff == 6'd2) quot_ff <= recip_prod[63:37];
            else                rem_ff  <= 11'(loss_diff);
         end else begin
            dividend_ff <= dividend_ff << 1;
            rem_ff      <= trial[11] ? {rem_ff[9:0], dividend_ff[31]} : trial[10:0];
         end
      end
   end

   // Delay and release time
   logic [31:0] delay_ff, release_ff, last_rel_ff;
   logic        last_valid_ff;
   logic [31:0] rel_raw, rel_diff;
   assign rel_raw  = now_ff + delay_ff;
   assign rel_diff = rel_raw - last_rel_ff;
   always_ff @(posedge clock) begin
      if (cmd.capture)      delay_ff <= 32'(latency_ff);
      else if (cmd.add_jit) delay_ff <= delay_ff + 32'(rem_ff);
      if (cmd.clamp) release_ff <= (last_valid_ff && rel_diff[31]) ? last_rel_ff : rel_raw;
   end

   // Queue memories and pointers
   logic [31:0] rt_mem  [QUEUE_DEPTH];
   logic [63:0] pay_mem [QUEUE_DEPTH];
   logic [11:0] sz_mem  [QUEUE_DEPTH];
   logic [31:0] rd_rt_ff;
   logic [63:0] rd_pay_ff;
   logic [11:0] rd_sz_ff;
   logic [AW-1:0] head_ff, tail, head_inc;
   logic [CW:0]   tail_sum;
   logic [CW-1:0] occ_ff, peak_ff, occ_next;
   logic [31:0] drop_cnt_ff, ovf_cnt_ff, del_cnt_ff, rel_cnt_ff;
   logic [31:0] pop_diff;
   logic        pop_due;

   // wrap pointers at the queue depth, which need not be a power of two
   assign tail_sum = {1'b0, CW'(head_ff)} + {1'b0, occ_ff};
   assign tail     = (tail_sum >= (CW+1)'(QUEUE_DEPTH)) ?
                     AW'(tail_sum - (CW+1)'(QUEUE_DEPTH)) : AW'(tail_sum);
   assign head_inc = (head_ff == AW'(QUEUE_DEPTH - 1)) ? '0 : head_ff + AW'(1);
   assign pop_diff = now_ff - rd_rt_ff;
   assign pop_due = (occ_ff != '0) && !pop_diff[31];

   always_ff @(posedge clock) begin
      if (cmd.write) begin
         rt_mem[tail]  <= release_ff;
         pay_mem[tail] <= pay_ff;
         sz_mem[tail]  <= size_ff;
      end
      if (cmd.read_head) begin
         rd_rt_ff  <= rt_mem[head_ff];
         rd_pay_ff <= pay_mem[head_ff];
         rd_sz_ff  <= sz_mem[head_ff];
      end
   end

   assign occ_next = occ_ff + CW'(1);

   // Response staging
   logic        acc_ff, ov_ff, forced_ff;
   logic [63:0] opay_ff;
   logic [11:0] osz_ff;

   always_ff @(posedge clock) begin
      if (reset || cmd.restart) begin
         head_ff <= '0; occ_ff <= '0; last_valid_ff <= 1'b0; last_rel_ff <= '0;
         drop_cnt_ff <= '0; ovf_cnt_ff <= '0; del_cnt_ff <= '0; rel_cnt_ff <= '0;
         peak_ff <= '0;
      end else begin
         if (cmd.flush) begin
            head_ff <= '0; occ_ff <= '0; last_valid_ff <= 1'b0;
         end
         if (cmd.drop) drop_cnt_ff <= drop_cnt_ff + 32'd1;
         if (cmd.evict) begin
            head_ff <= head_inc;
            occ_ff  <= occ_ff - CW'(1);
            ovf_cnt_ff <= ovf_cnt_ff + 32'd1;
         end
         if (cmd.write) begin
            occ_ff <= occ_next;
            last_rel_ff <= release_ff;
            last_valid_ff <= 1'b1;
            del_cnt_ff <= del_cnt_ff + 32'd1;
            if (occ_next > peak_ff) peak_ff <= occ_next;
         end
         if (cmd.pop && pop_due) begin
            head_ff <= head_inc;
            occ_ff  <= occ_ff - CW'(1);
            rel_cnt_ff <= rel_cnt_ff + 32'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         acc_ff <= 1'b0; ov_ff <= 1'b0; forced_ff <= 1'b0;
         opay_ff <= '0; osz_ff <= '0;
      end
      if (cmd.evict) begin
         ov_ff <= 1'b1; forced_ff <= 1'b1; opay_ff <= rd_pay_ff; osz_ff <= rd_sz_ff;
      end
      if (cmd.write) acc_ff <= 1'b1;
      if (cmd.pop && pop_due) begin
         acc_ff <= 1'b1; ov_ff <= 1'b1; opay_ff <= rd_pay_ff;
         osz_ff <= (rd_sz_ff < size_ff) ? rd_sz_ff : size_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_accepted <= acc_ff; rsp_out_valid <= ov_ff; rsp_out_payload <= opay_ff;
         rsp_out_size <= osz_ff; rsp_forced_out <= forced_ff;
         rsp_queued_now <= 9'(occ_ff);
         rsp_dropped_total <= drop_cnt_ff; rsp_overflow_total <= ovf_cnt_ff;
         rsp_delayed_total <= del_cnt_ff; rsp_released_total <= rel_cnt_ff;
         rsp_peak_occupancy <= 9'(peak_ff);
      end
   end

   always_comb begin
      status.req_type = cmd.capture ? req_type : type_ff;
      status.size_ok  = (size_ff != '0) && (size_ff <= 12'(MAX_PACKET_BYTES));
      status.loss_en  = !rel_ff && (loss_ff != '0);
      status.jit_en   = (jitter_ff != '0);
      status.div_busy = (cnt_ff != '0);
      status.lost     = ({4'd0, loss_ff} > rem_ff);
      status.full     = (occ_ff >= DEPTH_C);
   end

   `LDLQ_ASSERT_IMPLIES(a_occ_range, clock, reset, 1'b1, occ_ff <= DEPTH_C)
   `LDLQ_ASSERT_IMPLIES(a_peak_ge_occ, clock, reset, 1'b1, peak_ff >= occ_ff)
   `LDLQ_ASSERT_IMPLIES(a_write_not_full, clock, reset, cmd.write, occ_ff < DEPTH_C)
endmodule

### rtl/link_delay_loss_queue.sv
// Top level of the link delay loss queue: controller plus datapath.
// Depends on ldlq_pkg, ldlq_if, ldlq_ctrl and ldlq_dp.
`timescale 1ns / 1ps
//  channel  dir  payload
//  req      in   req_type, payload, pkt_size, reliable, now_ms
//  rsp      out  accepted, out_valid, out_payload, ... , peak_occupancy
//  csr      in   write_enable, index, write_data (32 bits)
// One request at a time.
// A submit forces out the oldest entry when the queue is full, and may draw for
// loss (reciprocal multiply by 1/100) and for jitter (one remainder bit per cycle).
// Reset is synchronous and leaves the queue empty, no clearing pass.
// A finished response waits in its register; the next request is taken
// once the controller has handed it over, even while the sink stalls.
module link_delay_loss_queue #(
   parameter int QUEUE_DEPTH      = 256,
   parameter int MAX_PACKET_BYTES = 2048
) (
   input  logic        clock,
   input  logic        reset,
   ldlq_req_if.sink    req,
   ldlq_rsp_if.source  rsp,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_write_data
);
   logic                 busy, req_fire, rsp_valid_ff, slot_free;
   ldlq_pkg::cmd_type    cmd;
   ldlq_pkg::status_type status;

   // accept a request only while the sequencer rests
   assign req.ready = !busy;
   assign req_fire  = req.valid && req.ready;
   // hand over once the output register is empty or being drained
   assign slot_free = !rsp_valid_ff || rsp.ready;

   always_ff @(posedge clock) begin
      if (reset)           rsp_valid_ff <= 1'b0;
      else if (cmd.finish) rsp_valid_ff <= 1'b1;
      else if (rsp.ready)  rsp_valid_ff <= 1'b0;
   end
   assign rsp.valid = rsp_valid_ff;

   ldlq_ctrl u_ctrl (
      .clock, .reset, .req_fire, .rsp_slot_free(slot_free), .status, .busy, .cmd
   );

   ldlq_dp #(.QUEUE_DEPTH(QUEUE_DEPTH), .MAX_PACKET_BYTES(MAX_PACKET_BYTES)) u_dp (
      .clock, .reset, .cmd, .status,
      .csr_write_enable, .csr_index, .csr_write_data,
      .req_type(req.req_type), .req_payload(req.payload), .req_pkt_size(req.pkt_size),
      .req_reliable(req.reliable), .req_now_ms(req.now_ms),
      .rsp_accepted(rsp.accepted), .rsp_out_valid(rsp.out_valid),
      .rsp_out_payload(rsp.out_payload), .rsp_out_size(rsp.out_size),
      .rsp_forced_out(rsp.forced_out), .rsp_queued_now(rsp.queued_now),
      .rsp_dropped_total(rsp.dropped_total), .rsp_overflow_total(rsp.overflow_total),
      .rsp_delayed_total(rsp.delayed_total), .rsp_released_total(rsp.released_total),
      .rsp_peak_occupancy(rsp.peak_occupancy)
   );
endmodule

### verif/testbench.sv
// Self-checking testbench for link_delay_loss_queue: directed table, overflow fill, then random requests.
// Depends on ldlq_pkg, ldlq_if and the block's RTL; predicts each response in place.
`timescale 1ns / 1ps
module testbench;
   localparam int DEPTH    = 256;
   localparam int MAX_SIZE = 2048;
   localparam int WATCHDOG = 20000;

   typedef struct packed {
      logic [1:0]  kind;
      logic [63:0] payload;
      logic [11:0] size;
      logic        reliable;
      logic [31:0] now;
   } request_type;

   typedef struct packed {
      logic        accepted;
      logic        out_valid;
      logic [63:0] out_payload;
      logic [11:0] out_size;
      logic        forced_out;
      logic [8:0]  queued_now;
      logic [31:0] dropped;
      logic [31:0] overflow;
      logic [31:0] delayed;
      logic [31:0] released;
      logic [8:0]  peak;
   } response_type;

   // Directed row: request plus an optional hand-typed expectation.
   typedef struct {
      request_type  rq;
      bit           typed;
      response_type rs;
   } row_type;

   logic clock = 0;
   logic reset = 1;
   logic        csr_write_enable = 0;
   logic [1:0]  csr_index = '0;
   logic [31:0] csr_write_data = '0;

   ldlq_req_if req ();
   ldlq_rsp_if rsp ();

   link_delay_loss_queue DUT (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Predictor state: shadow registers and queue contents.
   logic [12:0] lat_reg;
   logic [9:0]  jit_reg;
   logic [6:0]  loss_reg;
   logic [31:0] seed_reg;
   logic [31:0] rel_mem [DEPTH];
   logic [63:0] pay_mem [DEPTH];
   logic [11:0] size_mem [DEPTH];
   int unsigned head, occ, peak;
   logic [31:0] last_rel, rng;
   logic        last_rel_ok;
   logic [31:0] cnt_drop, cnt_ovf, cnt_delay, cnt_rel;

   response_type expected_responses[$];
   int  errors = 0;
   int  idle_cycles = 0;
   bit  timed_out = 0;

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
      errors++;
   endtask

   function automatic logic [31:0] next_random();
      logic [31:0] x;
      x = rng;
      x ^= x << 13;
      x ^= x >> 17;
      x ^= x << 5;
      rng = (x != 0) ? x : ldlq_pkg::SEED_DEFAULT;
      return rng;
   endfunction

   function automatic void restart_model();
      head = 0; occ = 0; peak = 0; last_rel_ok = 0; last_rel = 0;
      rng = (seed_reg != 0) ? seed_reg : ldlq_pkg::SEED_DEFAULT;
      cnt_drop = 0; cnt_ovf = 0; cnt_delay = 0; cnt_rel = 0;
   endfunction

   // Advance the model by one request and return the response it yields.
   function automatic response_type predict_response(request_type r);
      response_type o;
      logic [31:0] delay, rel, slot;
      o = '0;
      case (r.kind)
         ldlq_pkg::REQ_SUBMIT: begin
            if (r.size != 0 && r.size <= MAX_SIZE) begin
               if (!r.reliable && loss_reg != 0 &&
                   (next_random() % 100) < loss_reg) begin
                  cnt_drop++;
               end else begin
                  delay = 32'(lat_reg);
                  if (jit_reg != 0) delay += next_random() % (32'(jit_reg) + 32'd1);
                  rel = r.now + delay;
                  if (last_rel_ok && rel - last_rel >= 32'h8000_0000) rel = last_rel;
                  if (occ >= DEPTH) begin
                     o.out_valid = 1; o.forced_out = 1;
                     o.out_payload = pay_mem[head]; o.out_size = size_mem[head];
                     head = (head + 1) % DEPTH; occ--; cnt_ovf++;
                  end
                  slot = (head + occ) % DEPTH;
                  rel_mem[slot] = rel; pay_mem[slot] = r.payload; size_mem[slot] = r.size;
                  occ++; last_rel = rel; last_rel_ok = 1; cnt_delay++;
                  if (occ > peak) peak = occ;
                  o.accepted = 1;
               end
            end
         end
         ldlq_pkg::REQ_POP: begin
            if (occ > 0 && r.now - rel_mem[head] < 32'h8000_0000) begin
               o.accepted = 1; o.out_valid = 1;
               o.out_payload = pay_mem[head];
               o.out_size = (size_mem[head] < r.size) ? size_mem[head] : r.size;
               head = (head + 1) % DEPTH; occ--; cnt_rel++;
            end
         end
         ldlq_pkg::REQ_FLUSH: begin
            head = 0; occ = 0; last_rel_ok = 0;
         end
         default: restart_model();
      endcase
      o.queued_now = 9'(occ); o.dropped = cnt_drop; o.overflow = cnt_ovf;
      o.delayed = cnt_delay; o.released = cnt_rel; o.peak = 9'(peak);
      return o;
   endfunction

   function automatic int gap_length();
      int p;
      p = $urandom_range(0, 99);
      if (p < 55) return 0;
      if (p < 93) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // Hold a request until it is taken, then record its expected response.
   task automatic send_request(input request_type r, input bit typed,
                               input response_type want);
      response_type p;
      int g;
      req.valid    <= 1;
      req.req_type <= r.kind;
      req.payload  <= r.payload;
      req.pkt_size <= r.size;
      req.reliable <= r.reliable;
      req.now_ms   <= r.now;
      do @(posedge clock); while (!(req.ready === 1'b1));
      p = predict_response(r);
      if (typed && p !== want) begin
         report_mismatch("directed row vs predictor", p[63:0], want[63:0]);
      end
      expected_responses.push_back(p);
      @(negedge clock);
      g = gap_length();
      if (g != 0) begin
         req.valid <= 0;
         repeat (g) @(negedge clock);
      end
   endtask

   task automatic wait_drained();
      req.valid <= 0;
      while (expected_responses.size() != 0) @(negedge clock);
      repeat (80) @(negedge clock);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [31:0] data);
      csr_write_enable <= 1; csr_index <= idx; csr_write_data <= data;
      @(negedge clock);
      csr_write_enable <= 0;
      case (idx)
         ldlq_pkg::CSR_LATENCY: lat_reg  = data[12:0];
         ldlq_pkg::CSR_JITTER:  jit_reg  = data[9:0];
         ldlq_pkg::CSR_LOSS:    loss_reg = data[6:0];
         ldlq_pkg::CSR_SEED:    seed_reg = data;
         default: ;
      endcase
   endtask

   function automatic request_type make_request(logic [1:0] k, logic [63:0] pay,
                                                logic [11:0] sz, logic rel, logic [31:0] t);
      request_type r;
      r.kind = k; r.payload = pay; r.size = sz; r.reliable = rel; r.now = t;
      return r;
   endfunction

   // Random request; mostly submits and pops with times near a moving clock.
   function automatic request_type random_request(ref logic [31:0] clk_ms);
      request_type r;
      int p;
      p = $urandom_range(0, 99);
      clk_ms += $urandom_range(0, 40);
      r.payload  = {$urandom, $urandom};
      r.reliable = 1'($urandom_range(0, 1));
      r.now      = ($urandom_range(0, 30) == 0) ? $urandom : clk_ms;
      if (p < 52) begin
         r.kind = ldlq_pkg::REQ_SUBMIT;
         case ($urandom_range(0, 9))
            0: r.size = 12'($urandom_range(0, 4095));
            1: r.size = 12'(MAX_SIZE);
            default: r.size = 12'($urandom_range(1, 1500));
         endcase
      end else if (p < 96) begin
         r.kind = ldlq_pkg::REQ_POP;
         r.size = 12'($urandom_range(0, 4095));
         if ($urandom_range(0, 3) == 0) r.now = clk_ms + 3000;
      end else if (p < 99) begin
         r.kind = ldlq_pkg::REQ_FLUSH; r.size = 12'($urandom);
      end else begin
         r.kind = ldlq_pkg::REQ_RESTART; r.size = 12'($urandom);
      end
      return r;
   endfunction

   // Response side: random stalls, compare every accepted response.
   initial begin
      rsp.ready = 0;
      forever begin
         @(negedge clock);
         rsp.ready <= (gap_length() == 0) || ($urandom_range(0, 3) == 0);
      end
   end

   always @(posedge clock) begin
      response_type got, want;
      if (!reset && rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
         got = {rsp.accepted, rsp.out_valid, rsp.out_payload, rsp.out_size,
                rsp.forced_out, rsp.queued_now, rsp.dropped_total,
                rsp.overflow_total, rsp.delayed_total, rsp.released_total,
                rsp.peak_occupancy};
         if (expected_responses.size() == 0) begin
            report_mismatch("unexpected response", got[63:0], 0);
         end else begin
            want = expected_responses.pop_front();
            if (got.accepted !== want.accepted)
               report_mismatch("accepted", got.accepted, want.accepted);
            if (got.out_valid !== want.out_valid)
               report_mismatch("out_valid", got.out_valid, want.out_valid);
            if (got.out_payload !== want.out_payload)
               report_mismatch("out_payload", got.out_payload, want.out_payload);
            if (got.out_size !== want.out_size)
               report_mismatch("out_size", got.out_size, want.out_size);
            if (got.forced_out !== want.forced_out)
               report_mismatch("forced_out", got.forced_out, want.forced_out);
            if (got.queued_now !== want.queued_now)
               report_mismatch("queued_now", got.queued_now, want.queued_now);
            if (got.dropped !== want.dropped)
               report_mismatch("dropped_total", got.dropped, want.dropped);
            if (got.overflow !== want.overflow)
               report_mismatch("overflow_total", got.overflow, want.overflow);
            if (got.delayed !== want.delayed)
               report_mismatch("delayed_total", got.delayed, want.delayed);
            if (got.released !== want.released)
               report_mismatch("released_total", got.released, want.released);
            if (got.peak !== want.peak)
               report_mismatch("peak_occupancy", got.peak, want.peak);
         end
      end
   end

   // Watchdog: count cycles with no handshake on either channel.
   always @(posedge clock) begin
      if ((req.valid === 1'b1 && req.ready === 1'b1) ||
          (rsp.valid === 1'b1 && rsp.ready === 1'b1) || reset) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles > WATCHDOG && !timed_out) begin
         timed_out = 1;
         $display("testbench failed");
         $finish;
      end
   end

   // Stimulus.
   initial begin
      row_type rows[$];
      row_type row;
      response_type none;
      logic [31:0] clk_ms;
      int n;
      req.valid = 0; req.req_type = ldlq_pkg::REQ_SUBMIT; req.payload = '0;
      req.pkt_size = '0; req.reliable = 0; req.now_ms = '0;
      lat_reg = 0; jit_reg = 0; loss_reg = 0; seed_reg = 0;
      restart_model();
      none = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // Directed rows; the plain cases carry typed expectations.
      row.typed = 1; row.rs = none;
      row.rq = make_request(ldlq_pkg::REQ_POP, 0, 12'hFFF, 0, 0);          rows.push_back(row);
      row.rq = make_request(ldlq_pkg::REQ_SUBMIT, 0, 0, 1, 0);             rows.push_back(row);
      row.rq = make_request(ldlq_pkg::REQ_SUBMIT, '1, MAX_SIZE + 1, 1, 0); rows.push_back(row);
      row.rq = make_request(ldlq_pkg::REQ_SUBMIT, '1, 12'hFFF, 0, '1);     rows.push_back(row);
      row.rs = '{accepted:1, queued_now:1, delayed:1, peak:1, default:0};
      row.rq = make_request(ldlq_pkg::REQ_SUBMIT, '1, MAX_SIZE, 1, 0);     rows.push_back(row);
      row.rs = '{accepted:1, out_valid:1, out_payload:'1, out_size:MAX_SIZE,
                 peak:1, delayed:1, released:1, default:0};
      row.rq = make_request(ldlq_pkg::REQ_POP, 0, 12'hFFF, 0, 0);          rows.push_back(row);
      row.typed = 0;
      row.rq = make_request(ldlq_pkg::REQ_SUBMIT, 64'h1, 1, 0, 32'hFFFF_FFF0);
      rows.push_back(row);
      row.rq = make_request(ldlq_pkg::REQ_SUBMIT, 64'h2, 1, 1, 32'h0000_0010);
      rows.push_back(row);
      row.rq = make_request(ldlq_pkg::REQ_SUBMIT, 64'h3, 5, 1, 32'hFFFF_FF00);
      rows.push_back(row);
      row.rq = make_request(ldlq_pkg::REQ_POP, 0, 0, 0, 32'hFFFF_FFF8);    rows.push_back(row);
      row.rq = make_request(ldlq_pkg::REQ_POP, 0, 0, 0, 32'h0000_0020);    rows.push_back(row);
      row.rq = make_request(ldlq_pkg::REQ_POP, 0, 3, 0, 32'h0000_0020);    rows.push_back(row);
      row.rq = make_request(ldlq_pkg::REQ_POP, 0, 12'hFFF, 0, 32'h0000_0020);
      rows.push_back(row);
      row.rq = make_request(ldlq_pkg::REQ_SUBMIT, 64'h4, 9, 0, 32'h100);   rows.push_back(row);
      row.rq = make_request(ldlq_pkg::REQ_FLUSH, '1, 12'hFFF, 1, '1);      rows.push_back(row);
      row.rq = make_request(ldlq_pkg::REQ_POP, 0, 12'hFFF, 1, '1);         rows.push_back(row);
      row.rq = make_request(ldlq_pkg::REQ_RESTART, 0, 0, 0, 0);            rows.push_back(row);
      foreach (rows[i]) send_request(rows[i].rq, rows[i].typed, rows[i].rs);
      wait_drained();

      // Fill past depth so the oldest entry is forced out.
      for (int i = 0; i < DEPTH + 4; i++)
         send_request(make_request(ldlq_pkg::REQ_SUBMIT, {$urandom, $urandom},
                                   12'($urandom_range(1, MAX_SIZE)), 1, i), 0, none);
      send_request(make_request(ldlq_pkg::REQ_RESTART, 0, 0, 0, 0), 0, none);
      wait_drained();

      // Random phases over several register settings, extremes included.
      clk_ms = $urandom;
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: begin write_csr(ldlq_pkg::CSR_LATENCY, 0); write_csr(ldlq_pkg::CSR_JITTER, 0);
                     write_csr(ldlq_pkg::CSR_LOSS, 0); write_csr(ldlq_pkg::CSR_SEED, 0); end
            1: begin write_csr(ldlq_pkg::CSR_LATENCY, 32'h1FFF);
                     write_csr(ldlq_pkg::CSR_JITTER, 32'h3FF);
                     write_csr(ldlq_pkg::CSR_LOSS, 100); write_csr(ldlq_pkg::CSR_SEED, '1); end
            2: begin write_csr(ldlq_pkg::CSR_LATENCY, 5000);
                     write_csr(ldlq_pkg::CSR_JITTER, 1000);
                     write_csr(ldlq_pkg::CSR_LOSS, 127); write_csr(ldlq_pkg::CSR_SEED, 1); end
            default: begin
               write_csr(ldlq_pkg::CSR_LATENCY, $urandom_range(0, 60));
               write_csr(ldlq_pkg::CSR_JITTER, $urandom_range(0, 80));
               write_csr(ldlq_pkg::CSR_LOSS, $urandom_range(0, 50));
               write_csr(ldlq_pkg::CSR_SEED, $urandom);
            end
         endcase
         // Reload the generator with the new seed.
         send_request(make_request(ldlq_pkg::REQ_RESTART, 0, 0, 0, 0), 0, none);
         n = (phase < 3) ? 150 : 320;
         for (int i = 0; i < n; i++) begin
            if (i == n / 2) wait_drained();   // sender holds off until all is back
            send_request(random_request(clk_ms), 0, none);
         end
         wait_drained();
      end

      if (errors == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end
endmodule
